// ----- src/lkv_pkg.sv -----
package lkv_pkg;

    localparam int KIND_BITS = 2;
    localparam int CAP_BITS  = 5;

    typedef logic [KIND_BITS-1:0] kind_t;
    typedef logic [CAP_BITS-1:0]  cap_t;

    localparam kind_t KIND_GET   = 2'd0;
    localparam kind_t KIND_PUT   = 2'd1;
    localparam kind_t KIND_CLEAR = 2'd2;

    localparam cap_t CAP_RESET = 5'd16;

endpackage

// ----- src/lkv_req_if.sv -----
interface lkv_req_if
    import lkv_pkg::*;
#(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);

    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);

endinterface

// ----- src/lkv_rsp_if.sv -----
interface lkv_rsp_if
#(
    parameter int VALUE_BITS = 32
);

    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);

endinterface

// ----- src/lru_key_value_cache.sv -----
// datapath: a transaction is held in the input register, then its result is captured in the result register
// throughput: one operation per cycle while the response side is not stalled, set by the parallel key compare
// and recency-rank update across all entries between the input and result registers
// reset: valid bits, recency ranks and entry count clear at once, capacity returns to 16;
// key and value storage keep no reset and are never read before being written
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    lkv_req_if.sink       req,
    lkv_rsp_if.source     rsp,
    input  logic          cfg_we,
    input  logic [CAP_BITS-1:0] cfg_wdata
);

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

    // configuration
    cap_t capacity_reg;

    // entry storage
    logic [KEY_BITS-1:0]   key_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [AW-1:0]         age_reg   [ENTRIES];
    logic [AW-1:0]         age_next  [ENTRIES];
    logic [CW-1:0]         count_reg, count_next;

    // input stage
    logic                  in_valid_reg;
    kind_t                 in_kind_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_value_reg;

    // result stage
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [VALUE_BITS-1:0] read_value_reg;

    logic                  advance, proc;
    logic                  is_get, is_put, is_clear;
    logic [ENTRIES-1:0]    hit_vec, hit_one, old_vec, old_one;
    logic [ENTRIES-1:0]    evict_one, valid_after, free_vec, free_one;
    logic                  hit, free_any, evicted;
    logic [AW-1:0]         hit_idx, free_idx, hit_age, last_age;
    logic [CMPW-1:0]       cap_wide, cap_sat;
    logic                  cap_zero, need_evict;
    logic                  do_promote, do_insert;
    logic                  wr_en;
    logic [AW-1:0]         wr_idx;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;
    assign proc      = in_valid_reg && advance;

    assign is_get   = (in_kind_reg == KIND_GET);
    assign is_put   = (in_kind_reg == KIND_PUT);
    assign is_clear = (in_kind_reg == KIND_CLEAR);

    assign cap_wide   = CMPW'(capacity_reg);
    assign cap_sat    = (cap_wide > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_wide;
    assign cap_zero   = (capacity_reg == '0);
    assign need_evict = (CMPW'(count_reg) >= cap_sat);
    assign last_age   = AW'(count_reg - CW'(1));

    // parallel lookup; ranks among valid entries are unique, so the oldest holds count-1
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            old_vec[i] = valid_reg[i] && (age_reg[i] == last_age);
        end
    end

    assign hit_one     = hit_vec & (~hit_vec + 1'b1);
    assign old_one     = old_vec & (~old_vec + 1'b1);
    assign hit         = |hit_vec;
    assign evict_one   = need_evict ? old_one : '0;
    assign evicted     = |evict_one;
    assign valid_after = valid_reg & ~evict_one;
    assign free_vec    = ~valid_after;
    assign free_one    = free_vec & (~free_vec + 1'b1);
    assign free_any    = |free_vec;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        hit_age  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_one[i])
                hit_idx = hit_idx | AW'(i);
            if (free_one[i])
                free_idx = free_idx | AW'(i);
            hit_age = hit_age | ({AW{hit_one[i]}} & age_reg[i]);
        end
    end

    assign do_promote = proc && hit && (is_get || (is_put && !cap_zero));
    assign do_insert  = proc && is_put && !hit && !cap_zero;

    assign wr_en  = (do_promote && is_put) || (do_insert && free_any);
    assign wr_idx = do_insert ? free_idx : hit_idx;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
            age_next[i] = age_reg[i];

        if (proc && is_clear)
        begin
            valid_next = '0;
            count_next = '0;
            for (int i = 0; i < ENTRIES; i++)
                age_next[i] = '0;
        end
        else if (do_promote)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (hit_one[i])
                    age_next[i] = '0;
                else if (valid_reg[i] && (age_reg[i] < hit_age))
                    age_next[i] = age_reg[i] + 1'b1;
            end
        end
        else if (do_insert)
        begin
            valid_next = valid_after | (free_any ? free_one : '0);
            count_next = count_reg - CW'(evicted) + CW'(free_any);
            if (free_any)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (free_one[i])
                        age_next[i] = '0;
                    else if (valid_after[i])
                        age_next[i] = age_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
                age_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
                age_reg[i] <= age_next[i];
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers and storage
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_kind_reg  <= req.kind;
            in_key_reg   <= req.key;
            in_value_reg <= req.value;
        end
        if (do_insert && free_any)
            key_reg[free_idx] <= in_key_reg;
        if (wr_en)
            value_mem[wr_idx] <= in_value_reg;
        if (advance)
        begin
            found_reg      <= in_valid_reg && hit && (is_get || is_put);
            read_value_reg <= (in_valid_reg && is_get && hit) ? value_mem[hit_idx] : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = read_value_reg;

`ifndef SYNTH
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count disagrees with valid bits");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(hit_vec))
        else $error("key present in more than one entry");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && is_clear) |=> (count_reg == '0) && (valid_reg == '0))
        else $error("clear left entries behind");

    a_stalled_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_key_reg))
        else $error("stalled input transaction was lost");
`endif

endmodule
